>>> rtl/core/sym3inv_pkg.sv
package sym3inv_pkg;

   localparam int NUM_ELEM = 6;
   localparam int ELEM_W   = 32;
   localparam int CMAG_W   = 64;
   localparam int DET_W    = 98;
   localparam int QUO_W    = 33;

   localparam logic [ELEM_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [ELEM_W-1:0] SAT_NEG = 32'h8000_0000;
   localparam logic [QUO_W-1:0]  QUO_POS_MAX = 33'h0_7FFF_FFFF;
   localparam logic [QUO_W-1:0]  QUO_NEG_MAX = 33'h0_8000_0000;
   localparam logic [63:0]       THRESH_RESET = 64'd281474977;

   // cofactor magnitudes and signs plus determinant, handed from front to back
   typedef struct packed {
      logic [NUM_ELEM-1:0][CMAG_W-1:0] cmag;
      logic [NUM_ELEM-1:0]             cneg;
      logic [DET_W-1:0]                dmag;
      logic                            dneg;
      logic                            sing;
   } mid_item_type;

   typedef struct packed {
      logic [NUM_ELEM-1:0][ELEM_W-1:0] inv;
      logic                            singular;
      logic                            saturated;
   } rsp_item_type;

endpackage

>>> rtl/core/sym3inv_queue.sv
module sym3inv_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic             full
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CW'(DEPTH));
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != CW'(DEPTH)))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue pop while empty");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> !empty)
      else $error("queue lost an item");

endmodule

>>> rtl/core/sym3inv_front.sv
module sym3inv_front (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   output logic                                        in_ready,
   input  logic [sym3inv_pkg::NUM_ELEM-1:0][sym3inv_pkg::ELEM_W-1:0] elems,
   input  logic [63:0]                                 threshold,
   output logic                                        out_push,
   output sym3inv_pkg::mid_item_type                   out_item,
   input  logic                                        out_full
);
   import sym3inv_pkg::*;

   localparam int A00 = 0;
   localparam int A11 = 1;
   localparam int A22 = 2;
   localparam int A01 = 3;
   localparam int A02 = 4;
   localparam int A12 = 5;

   // cofactor k = prod(2k) - prod(2k+1)
   localparam int MUL_X [12] = '{A11, A12, A00, A02, A00, A01, A02, A01, A01, A02, A01, A00};
   localparam int MUL_Y [12] = '{A22, A12, A22, A02, A11, A01, A12, A22, A12, A11, A02, A12};
   // row 0 expansion: a00 with c0, a01 with c3, a02 with c4
   localparam int TERM_A [3] = '{A00, A01, A02};
   localparam int TERM_C [3] = '{0, 3, 4};

   function automatic logic [63:0] smul(input logic [31:0] x, input logic [31:0] y);
      smul = $signed(x) * $signed(y);
   endfunction

   logic en;
   logic [7:1] v_ff;

   logic [NUM_ELEM-1:0][ELEM_W-1:0] a_ff;
   logic [11:0][63:0]               prod_ff, prod_in;
   logic [2:0][31:0]                amag2_ff, amag2_in, amag3_ff;
   logic [2:0]                      asgn2_ff, asgn2_in, asgn3_ff;
   logic [NUM_ELEM-1:0][CMAG_W-1:0] cmag3_ff, cmag3_in, cmag4_ff, cmag5_ff, cmag6_ff, cmag7_ff;
   logic [NUM_ELEM-1:0]             cneg3_ff, cneg3_in, cneg4_ff, cneg5_ff, cneg6_ff, cneg7_ff;
   logic [2:0][63:0]                plo_ff, plo_in, phi_ff, phi_in;
   logic [2:0]                      tneg_ff, tneg_in;
   logic [2:0][DET_W-1:0]           term_ff, term_in;
   logic [DET_W-1:0]                det_ff, det_in, dmag_ff, dmag_in;
   logic                            dneg_ff;

   assign en       = !(v_ff[7] && out_full);
   assign in_ready = en;
   assign out_push = en && v_ff[7];

   always_comb begin
      logic [64:0] c;
      logic [95:0] mag;
      for (int k = 0; k < 12; k++) begin
         prod_in[k] = smul(a_ff[MUL_X[k]], a_ff[MUL_Y[k]]);
      end
      for (int t = 0; t < 3; t++) begin
         asgn2_in[t] = a_ff[TERM_A[t]][31];
         amag2_in[t] = asgn2_in[t] ? (32'd0 - a_ff[TERM_A[t]]) : a_ff[TERM_A[t]];
      end
      for (int k = 0; k < NUM_ELEM; k++) begin
         c = {prod_ff[2*k][63], prod_ff[2*k]} - {prod_ff[2*k+1][63], prod_ff[2*k+1]};
         cneg3_in[k] = c[64];
         cmag3_in[k] = c[64] ? 64'(65'd0 - c) : c[63:0];
      end
      for (int t = 0; t < 3; t++) begin
         plo_in[t]  = amag3_ff[t] * cmag3_ff[TERM_C[t]][31:0];
         phi_in[t]  = amag3_ff[t] * cmag3_ff[TERM_C[t]][63:32];
         tneg_in[t] = asgn3_ff[t] ^ cneg3_ff[TERM_C[t]];
      end
      for (int t = 0; t < 3; t++) begin
         mag = {phi_ff[t], 32'd0} + {32'd0, plo_ff[t]};
         term_in[t] = tneg_ff[t] ? (DET_W'(0) - {2'b00, mag}) : {2'b00, mag};
      end
      det_in  = term_ff[0] + term_ff[1] + term_ff[2];
      dmag_in = det_ff[DET_W-1] ? (DET_W'(0) - det_ff) : det_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[6:1], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff     <= elems;
         prod_ff  <= prod_in;
         amag2_ff <= amag2_in;
         asgn2_ff <= asgn2_in;
         amag3_ff <= amag2_ff;
         asgn3_ff <= asgn2_ff;
         cmag3_ff <= cmag3_in;
         cneg3_ff <= cneg3_in;
         plo_ff   <= plo_in;
         phi_ff   <= phi_in;
         tneg_ff  <= tneg_in;
         cmag4_ff <= cmag3_ff;
         cneg4_ff <= cneg3_ff;
         term_ff  <= term_in;
         cmag5_ff <= cmag4_ff;
         cneg5_ff <= cneg4_ff;
         det_ff   <= det_in;
         cmag6_ff <= cmag5_ff;
         cneg6_ff <= cneg5_ff;
         dmag_ff  <= dmag_in;
         dneg_ff  <= det_ff[DET_W-1];
         cmag7_ff <= cmag6_ff;
         cneg7_ff <= cneg6_ff;
      end
   end

   // exact zero is always singular, whatever the threshold
   always_comb begin
      out_item.cmag = cmag7_ff;
      out_item.cneg = cneg7_ff;
      out_item.dmag = dmag_ff;
      out_item.dneg = dneg_ff;
      out_item.sing = (dmag_ff[DET_W-1:64] == '0)
                   && ((dmag_ff[63:0] < threshold) || (dmag_ff[63:0] == 64'd0));
   end

endmodule

>>> rtl/core/sym3inv_back.sv
module sym3inv_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_take,
   input  sym3inv_pkg::mid_item_type  in_item,
   output logic                       out_push,
   output sym3inv_pkg::rsp_item_type  out_item,
   input  logic                       out_full
);
   import sym3inv_pkg::*;

   localparam int RW = DET_W + QUO_W + 1;
   localparam int NS = QUO_W + 1;

   logic en;
   logic [NS-1:0] v_ff, v_in;

   logic [NUM_ELEM-1:0][RW-1:0]    rem_ff  [NS];
   logic [NUM_ELEM-1:0][RW-1:0]    rem_in  [NS];
   logic [NUM_ELEM-1:0][QUO_W-1:0] q_ff    [NS];
   logic [NUM_ELEM-1:0][QUO_W-1:0] q_in    [NS];
   logic [NUM_ELEM-1:0]            ovf_ff  [NS];
   logic [NUM_ELEM-1:0]            ovf_in  [NS];
   logic [NUM_ELEM-1:0]            neg_ff  [NS];
   logic [NUM_ELEM-1:0]            neg_in  [NS];
   logic [DET_W-1:0]               d_ff    [NS];
   logic [DET_W-1:0]               d_in    [NS];
   logic [NS-1:0]                  sing_ff, sing_in;

   assign en       = !(v_ff[NS-1] && out_full);
   assign in_take  = en && in_valid;
   assign out_push = en && v_ff[NS-1];

   always_comb begin
      logic [RW-1:0] dsh;
      logic          ge;
      v_in[0]    = in_valid;
      d_in[0]    = in_item.dmag;
      sing_in[0] = in_item.sing;
      for (int k = 0; k < NUM_ELEM; k++) begin
         rem_in[0][k] = RW'(in_item.cmag[k]) << (2 * FRAC_BITS);
         q_in[0][k]   = '0;
         ovf_in[0][k] = 1'b0;
         neg_in[0][k] = in_item.cneg[k] ^ in_item.dneg;
      end
      // one restoring step per stage, quotient msb first
      for (int s = 0; s < QUO_W; s++) begin
         v_in[s+1]    = v_ff[s];
         d_in[s+1]    = d_ff[s];
         sing_in[s+1] = sing_ff[s];
         neg_in[s+1]  = neg_ff[s];
         for (int k = 0; k < NUM_ELEM; k++) begin
            dsh = RW'(d_ff[s]) << (QUO_W - 1 - s);
            ge  = (rem_ff[s][k] >= dsh);
            rem_in[s+1][k] = ge ? (rem_ff[s][k] - dsh) : rem_ff[s][k];
            q_in[s+1][k]   = {q_ff[s][k][QUO_W-2:0], ge};
            if (s == 0) begin
               ovf_in[s+1][k] = (rem_ff[s][k] >= (RW'(d_ff[s]) << QUO_W));
            end else begin
               ovf_in[s+1][k] = ovf_ff[s][k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         q_ff    <= q_in;
         ovf_ff  <= ovf_in;
         neg_ff  <= neg_in;
         d_ff    <= d_in;
         sing_ff <= sing_in;
      end
   end

   // sign, clip and zero for singular
   always_comb begin
      logic [QUO_W-1:0]    q;
      logic                neg;
      logic [NUM_ELEM-1:0] sat;
      for (int k = 0; k < NUM_ELEM; k++) begin
         q   = q_ff[NS-1][k];
         neg = neg_ff[NS-1][k];
         sat[k] = ovf_ff[NS-1][k] || (neg ? (q > QUO_NEG_MAX) : (q > QUO_POS_MAX));
         if (sing_ff[NS-1]) begin
            out_item.inv[k] = '0;
         end else if (sat[k]) begin
            out_item.inv[k] = neg ? SAT_NEG : SAT_POS;
         end else begin
            out_item.inv[k] = neg ? (32'd0 - q[31:0]) : q[31:0];
         end
      end
      out_item.singular  = sing_ff[NS-1];
      out_item.saturated = !sing_ff[NS-1] && (sat != '0);
   end

endmodule

>>> rtl/core/symmetric_3x3_inverse_top.sv
// channel | direction | handshake          | payload
// req     | in        | req_push / req_full | six elements, signed q16.16
// rsp     | out       | rsp_pop / rsp_empty | six inverse elements, singular, saturated
// csr     | in        | csr_write_en        | 64-bit singular threshold, q48
//
// one item per cycle sustained while rsp is popped and no queue fills; the path is 7 front stages,
// mid queue, 34 divider stages, output queue
// the divider is 33 restoring steps in a row, one per stage, six lanes wide
// reset is synchronous, active high; clears queues and valids and loads the threshold with THRESH_RESET
// a held rsp stalls the divider pipe, and a full mid queue stalls the front pipe;
// req_full follows only registered state
module symmetric_3x3_inverse_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_a00,
   input  logic [31:0] req_a11,
   input  logic [31:0] req_a22,
   input  logic [31:0] req_a01,
   input  logic [31:0] req_a02,
   input  logic [31:0] req_a12,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_inv00,
   output logic [31:0] rsp_inv11,
   output logic [31:0] rsp_inv22,
   output logic [31:0] rsp_inv01,
   output logic [31:0] rsp_inv02,
   output logic [31:0] rsp_inv12,
   output logic        rsp_singular,
   output logic        rsp_saturated,
   input  logic        csr_write_en,
   input  logic [63:0] csr_write_data
);
   import sym3inv_pkg::*;

   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 2;

   // singular threshold register
   logic [63:0] thresh_ff, thresh_in;

   logic [NUM_ELEM-1:0][ELEM_W-1:0] elems;
   logic         front_ready;
   logic         mid_push, mid_pop, mid_empty, mid_full;
   mid_item_type mid_wr, mid_rd;
   logic [$bits(mid_item_type)-1:0] mid_rd_bits;
   logic         out_push, out_full;
   rsp_item_type out_wr, out_rd;
   logic [$bits(rsp_item_type)-1:0] out_rd_bits;

   assign thresh_in = csr_write_en ? csr_write_data : thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   // element order matches the front's cofactor table
   assign elems    = {req_a12, req_a02, req_a01, req_a22, req_a11, req_a00};
   assign req_full = !front_ready;

   // cofactors, determinant and singular test
   sym3inv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_push),
      .in_ready  (front_ready),
      .elems     (elems),
      .threshold (thresh_ff),
      .out_push  (mid_push),
      .out_item  (mid_wr),
      .out_full  (mid_full)
   );

   // short queue decoupling front and divider
   sym3inv_queue #(
      .WIDTH ($bits(mid_item_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_wr),
      .pop       (mid_pop),
      .pop_data  (mid_rd_bits),
      .empty     (mid_empty),
      .full      (mid_full)
   );

   assign mid_rd = mid_item_type'(mid_rd_bits);

   // six pipelined dividers and output clipping
   sym3inv_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (!mid_empty),
      .in_take  (mid_pop),
      .in_item  (mid_rd),
      .out_push (out_push),
      .out_item (out_wr),
      .out_full (out_full)
   );

   // result queue, head item sits on the rsp ports
   sym3inv_queue #(
      .WIDTH ($bits(rsp_item_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_wr),
      .pop       (rsp_pop && !rsp_empty),
      .pop_data  (out_rd_bits),
      .empty     (rsp_empty),
      .full      (out_full)
   );

   assign out_rd        = rsp_item_type'(out_rd_bits);
   assign rsp_inv00     = out_rd.inv[0];
   assign rsp_inv11     = out_rd.inv[1];
   assign rsp_inv22     = out_rd.inv[2];
   assign rsp_inv01     = out_rd.inv[3];
   assign rsp_inv02     = out_rd.inv[4];
   assign rsp_inv12     = out_rd.inv[5];
   assign rsp_singular  = out_rd.singular;
   assign rsp_saturated = out_rd.saturated;

endmodule
